// File: src/npc_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, types and register codes for the pattern counter.
package npc_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int COUNT_BITS  = 16;
  localparam int PAT_BYTES   = 32;
  localparam int PAT_WORDS   = PAT_BYTES / 8;
  localparam int LEN_W       = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_CNT_W   = 16;
  localparam int CELL_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SINCE_W     = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
  localparam int CMP_W       = ((CELL_W > LEN_W) ? CELL_W : LEN_W) + 1;

  typedef logic [7:0] byte_t;
  typedef byte_t [PAT_BYTES-1:0] pat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN   = 3'd0,
    CFG_WORD0 = 3'd1,
    CFG_WORD1 = 3'd2,
    CFG_WORD2 = 3'd3,
    CFG_WORD3 = 3'd4
  } cfg_idx_t;

  // one result item
  typedef struct packed {
    logic                 match_here;
    logic [OUT_CNT_W-1:0] matches_so_far;
  } res_t;

endpackage

// File: src/npc_ifs.sv
`timescale 1ns / 1ps
// Interfaces: text input channel and result channel, valid/ready handshake.
interface npc_in_if
  import npc_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  start_of_text;

  modport source (output valid, output text_byte, output start_of_text, input ready);
  modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

interface npc_out_if
  import npc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 match_here;
  logic [OUT_CNT_W-1:0] matches_so_far;

  modport source (output valid, output match_here, output matches_so_far, input ready);
  modport sink   (input valid, input match_here, input matches_so_far, output ready);
endinterface

// File: src/npc_cell.sv
`timescale 1ns / 1ps
// Window cell: holds one recent text byte and compares it to its pattern byte.
module npc_cell
  import npc_pkg::*;
(
  input  logic              clk,
  input  logic [CELL_W-1:0] cell_idx,   // position in the window, 0 newest
  input  logic              shift_en,   // item accepted
  input  logic              clear,      // new text: drop the older byte
  input  byte_t             byte_in,    // from the neighbor or the input
  input  logic [LEN_W-1:0]  len,
  input  pat_t              pat_bytes,
  output byte_t             byte_q,     // to the next neighbor
  output logic              eq_ok       // match condition for this position
);

  byte_t            byte_r;
  byte_t            byte_nxt;
  logic [CMP_W-1:0] k_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] pidx;

  // byte this cell holds after the shift
  always_comb begin
    byte_nxt = clear ? '0 : byte_in;
  end

  // compare against pattern byte len-1-k; cells beyond the length don't care
  always_comb begin
    k_ext   = CMP_W'(cell_idx);
    len_ext = CMP_W'(len);
    pidx    = len_ext - k_ext - CMP_W'(1);
    eq_ok   = (k_ext >= len_ext) || (byte_nxt == pat_bytes[pidx[PAT_IDX_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

// File: src/npc_obuf.sv
`timescale 1ns / 1ps
// Output buffer: result register plus skid entry so input waits only when both entries are full.
module npc_obuf
  import npc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  npc_out_if.source out_ch
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop        = main_valid_r && out_ch.ready;
  assign push_ready = !skid_valid_r;

  // move items main <- skid <- push
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid          = main_valid_r;
  assign out_ch.match_here     = main_r.match_here;
  assign out_ch.matches_so_far = main_r.matches_so_far;

`ifndef SYNTHESIS
  // skid entry is only used while the result register is occupied
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid while result register empty");

  // a stalled result is not replaced
  a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !out_ch.ready |=> main_valid_r && main_r == $past(main_r))
    else $error("stalled result changed");

  // no push is taken while both entries are full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && skid_valid_r && !out_ch.ready |=> skid_valid_r && skid_r == $past(skid_r))
    else $error("skid entry overwritten");
`endif

endmodule

// File: src/nonoverlap_pattern_counter.sv
`timescale 1ns / 1ps
// Top level: non-overlapping byte pattern counter over a text stream.
//
// Takes one text byte per clock while in_ch.ready is high and returns one
// result per byte: whether a counted (leftmost, non-overlapping) match of the
// configured pattern ends at that byte, and the saturating match count of the
// current text. A row of 32 cells shifts the recent bytes along and compares
// each one with its pattern byte in the cycle the byte arrives; results go to
// the output register, or to a skid entry behind it while that register is
// stalled, and input waits only when the skid entry is full too. A pattern
// length of zero or above 32 never matches. start_of_text on a byte begins a
// new text with that byte. The user writes pattern registers through the cfg
// port between texts or while no item is in flight; the block does not enforce it.
module nonoverlap_pattern_counter
  import npc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  npc_in_if.sink                in_ch,
  npc_out_if.source             out_ch
);

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] pat_word_r [PAT_WORDS];
  pat_t                  pat_bytes;

  logic [SINCE_W-1:0]    since_r, since_nxt, since_inc;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt, tally_base;

  byte_t                 win_q  [MAX_PATTERN];
  byte_t                 cell_in[MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_ok;

  logic acc;
  logic push_ready;
  logic len_ok;
  logic since_ok;
  logic hit;
  res_t res;

  assign in_ch.ready = push_ready;
  assign acc         = in_ch.valid && push_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEN:   len_r         <= cfg_data[LEN_W-1:0];
        CFG_WORD0: pat_word_r[0] <= cfg_data;
        CFG_WORD1: pat_word_r[1] <= cfg_data;
        CFG_WORD2: pat_word_r[2] <= cfg_data;
        CFG_WORD3: pat_word_r[3] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // pattern bytes, byte 0 in the lowest bits of word 0
  for (genvar b = 0; b < PAT_BYTES; b++) begin : g_pat
    assign pat_bytes[b] = pat_word_r[b / 8][(b % 8) * 8 +: 8];
  end

  // the window: cell 0 takes the text byte, each other cell its neighbor
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_ch.text_byte;
    end else begin : g_body
      assign cell_in[k] = win_q[k-1];
    end

    npc_cell u_cell (
      .clk       (clk),
      .cell_idx  (CELL_W'(k)),
      .shift_en  (acc),
      .clear     (in_ch.start_of_text && (k != 0)),
      .byte_in   (cell_in[k]),
      .len       (len_r),
      .pat_bytes (pat_bytes),
      .byte_q    (win_q[k]),
      .eq_ok     (eq_ok[k])
    );
  end

  // bytes since text start or last match, saturating at the window size
  always_comb begin
    since_inc = in_ch.start_of_text ? '0 : since_r;
    if (since_inc < SINCE_W'(MAX_PATTERN)) begin
      since_inc = since_inc + SINCE_W'(1);
    end
  end

  // match decision
  always_comb begin
    len_ok   = (len_r != '0) && (CMP_W'(len_r) <= CMP_W'(MAX_PATTERN)) &&
               (CMP_W'(len_r) <= CMP_W'(PAT_BYTES));
    since_ok = CMP_W'(since_inc) >= CMP_W'(len_r);
    hit      = len_ok && since_ok && (&eq_ok);
  end

  // counter updates
  always_comb begin
    tally_base = in_ch.start_of_text ? '0 : tally_r;
    tally_nxt  = tally_base;
    since_nxt  = since_inc;
    if (hit) begin
      since_nxt = '0;
      if (tally_base != '1) begin
        tally_nxt = tally_base + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= '0;
      tally_r <= '0;
    end else if (acc) begin
      since_r <= since_nxt;
      tally_r <= tally_nxt;
    end
  end

  // result item
  always_comb begin
    res.match_here     = hit;
    res.matches_so_far = OUT_CNT_W'(tally_nxt);
  end

  npc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .push_data  (res),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // a counted match restarts the distance count
  a_hit_clears_since: assert property (@(posedge clk) disable iff (!rst_n)
    acc && hit |=> since_r == '0)
    else $error("distance count not cleared after a match");

  // the tally only moves back on a new text
  a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_ch.start_of_text |=> tally_r >= $past(tally_r))
    else $error("match tally decreased within a text");

  // zero length never matches
  a_zero_len_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (len_r == '0) |-> !hit)
    else $error("match reported with zero pattern length");
`endif

endmodule

// File: tb/tb_nonoverlap_pattern_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the non-overlapping pattern counter: directed table, random texts.
module tb_nonoverlap_pattern_counter;
  import npc_pkg::*;

  localparam int IDLE_PCT       = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int MAX_REPORTS    = 10;
  localparam int ALPHA_N        = 3;
  localparam int LONG_PHASE     = 2;
  localparam int HOLD_PHASE     = 5;
  localparam int MAX_LEN_CODE   = (1 << LEN_W) - 1;
  localparam int FIRST_UNUSED_IDX = int'(CFG_WORD3) + 1;
  localparam byte_t CH_A        = 8'h61;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table: either a register write or a text byte
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    byte_t                 b;
    logic                  sot;
    logic                  pinned;
    res_t                  want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  npc_in_if  in_ch ();
  npc_out_if out_ch ();

  nonoverlap_pattern_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state and its copy of the pattern registers
  byte_t                 win_bytes [MAX_PATTERN];
  int unsigned           since_cnt;
  logic [COUNT_BITS-1:0] tally;
  logic [LEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0] pat_words [PAT_WORDS];

  // expected results, oldest first
  res_t pending_q [$];

  // stimulus shaping
  byte_t cur_pat [PAT_BYTES];
  byte_t alphabet [ALPHA_N];
  logic  begin_text;
  logic  no_idle;
  logic  rx_hold_req;

  int unsigned bytes_sent, random_items, texts_begun, matches_seen;
  int unsigned cfg_writes, settings_used, results_checked, fail_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one text byte through the counter: shift window, compare, count
  function automatic res_t count_step(byte_t b, logic sot);
    res_t        r;
    logic        hit;
    int unsigned len;
    if (sot) begin
      foreach (win_bytes[i]) win_bytes[i] = '0;
      since_cnt = 0;
      tally     = '0;
    end
    for (int i = MAX_PATTERN - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (since_cnt < MAX_PATTERN) since_cnt++;
    len = pat_len;
    // zero and overlong lengths never match; a match may not reuse bytes
    hit = (len != 0) && (len <= MAX_PATTERN) && (len <= PAT_BYTES) && (since_cnt >= len);
    if (hit) begin
      for (int i = 0; i < len; i++)
        if (win_bytes[len-1-i] != pat_words[i/8][(i%8)*8 +: 8]) hit = 1'b0;
    end
    if (hit) begin
      since_cnt = 0;
      if (tally != '1) tally++;
    end
    r.match_here     = hit;
    r.matches_so_far = tally[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("MISMATCH %0d at %0t: %s", fail_count, $time, msg);
  endfunction

  function automatic dir_row_t item_row(byte_t b, logic sot, logic pinned, logic m,
                                        logic [OUT_CNT_W-1:0] c);
    dir_row_t row;
    row.kind                = ROW_ITEM;
    row.idx                 = '0;
    row.data                = '0;
    row.b                   = b;
    row.sot                 = sot;
    row.pinned              = pinned;
    row.want.match_here     = m;
    row.want.matches_so_far = c;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind   = ROW_CFG;
    row.idx    = idx;
    row.data   = val;
    row.b      = '0;
    row.sot    = 1'b0;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  // register write; only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LEN:   pat_len = val[LEN_W-1:0];
      CFG_WORD0: pat_words[0] = val;
      CFG_WORD1: pat_words[1] = val;
      CFG_WORD2: pat_words[2] = val;
      CFG_WORD3: pat_words[3] = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // load cur_pat into the word registers, then the length (junk above its bits)
  task automatic apply_pattern(int len);
    logic [CFG_DATA_W-1:0] word;
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int k = 0; k < 8; k++) word[k*8 +: 8] = cur_pat[w*8 + k];
      write_reg(cfg_idx_t'(int'(CFG_WORD0) + w), word);
    end
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = len[LEN_W-1:0];
    write_reg(CFG_LEN, word);
    settings_used++;
  endtask

  // stop offering, wait for every expected result, then let the pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // offer one item, wait for the handshake, record its expected result
  task automatic send_text_byte(byte_t b, logic sot, logic pinned, res_t pinned_res);
    res_t predicted;
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.text_byte     <= b;
    in_ch.start_of_text <= sot;
    do @(posedge clk); while (!in_ch.ready);
    predicted = count_step(b, sot);
    pending_q.push_back(pinned ? pinned_res : predicted);
    bytes_sent++;
    if (sot) texts_begun++;
    if (predicted.match_here) matches_seen++;
  endtask

  // random-part item: start flag on the first byte of a text, rarely elsewhere
  task automatic emit(byte_t b);
    logic sot;
    sot        = begin_text || ($urandom_range(99) < 3);
    begin_text = 1'b0;
    send_text_byte(b, sot, 1'b0, '0);
    random_items++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_q.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected: match_here=%0b count=%0d",
                               results_checked, out_ch.match_here, out_ch.matches_so_far));
      end else begin
        want = pending_q.pop_front();
        if (out_ch.match_here !== want.match_here)
          note_failure($sformatf("result %0d match_here: expected %0b, got %0b",
                                 results_checked, want.match_here, out_ch.match_here));
        if (out_ch.matches_so_far !== want.matches_so_far)
          note_failure($sformatf("result %0d matches_so_far: expected %0d, got %0d",
                                 results_checked, want.matches_so_far, out_ch.matches_so_far));
      end
    end
  end

  // watchdog: cycles with no handshake and no register write
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    int unsigned r;
    int          len, eff_len, run_len, chunk_len, phase_start, phase;

    // known values on every input from time zero
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.text_byte     <= '0;
    in_ch.start_of_text <= 1'b0;
    no_idle     = 1'b0;
    rx_hold_req = 1'b0;
    begin_text  = 1'b0;
    foreach (win_bytes[i]) win_bytes[i] = '0;
    foreach (pat_words[i]) pat_words[i] = '0;
    since_cnt = 0;
    tally     = '0;
    pat_len   = '0;
    bytes_sent = 0; random_items = 0; texts_begun = 0; matches_seen = 0;
    cfg_writes = 0; settings_used = 0; results_checked = 0; fail_count = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    // after reset the length is zero, so even a zero byte against zero words stays silent
    rows.push_back(item_row(8'h00, 1'b1, 1'b1, 1'b0, 16'd0));
    rows.push_back(item_row(8'hFF, 1'b0, 1'b1, 1'b0, 16'd0));
    // single zero byte pattern: every zero byte counts
    rows.push_back(cfg_row(CFG_LEN, 64'd1));
    rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 16'd1));
    rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 16'd2));
    // start flag clears the count
    rows.push_back(item_row(8'hFF, 1'b1, 1'b1, 1'b0, 16'd0));
    // "aa" over "aaaa": two matches, the overlapping one is skipped
    rows.push_back(cfg_row(CFG_WORD0, {48'h0, CH_A, CH_A}));
    rows.push_back(cfg_row(CFG_LEN, 64'd2));
    rows.push_back(item_row(CH_A, 1'b1, 1'b1, 1'b0, 16'd0));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b1, 16'd1));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b0, 16'd1));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b1, 16'd2));
    // length change in the middle of a text
    rows.push_back(cfg_row(CFG_LEN, 64'd1));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b1, 16'd3));
    // overlong lengths never match
    rows.push_back(cfg_row(CFG_LEN, 64'd33));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b0, 16'd3));
    rows.push_back(cfg_row(CFG_LEN, 64'(MAX_LEN_CODE)));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b0, 16'd3));
    // a write to an unused index changes nothing
    rows.push_back(cfg_row(FIRST_UNUSED_IDX[CFG_IDX_W-1:0], '1));
    rows.push_back(item_row(CH_A, 1'b0, 1'b1, 1'b0, 16'd3));
    rows.push_back(cfg_row(CFG_LEN, 64'd2));
    rows.push_back(item_row(8'h80, 1'b0, 1'b0, 1'b0, 16'd0));
    rows.push_back(item_row(CH_A, 1'b0, 1'b0, 1'b0, 16'd0));
    rows.push_back(item_row(CH_A, 1'b0, 1'b0, 1'b0, 16'd0));
    rows.push_back(item_row(8'h7F, 1'b1, 1'b0, 1'b0, 16'd0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_text_byte(rows[i].b, rows[i].sot, rows[i].pinned, rows[i].want);
      end
    end

    // random texts, one pattern setting per phase
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_idle = (phase == LONG_PHASE) || (phase == HOLD_PHASE);
      drain_results();

      foreach (alphabet[i]) alphabet[i] = byte_t'($urandom);
      r = $urandom_range(99);
      if (r < 8)       len = 0;
      else if (r < 18) len = PAT_BYTES;
      else if (r < 26) len = $urandom_range(MAX_LEN_CODE, PAT_BYTES + 1);
      else if (r < 40) len = $urandom_range(PAT_BYTES - 1, 9);
      else             len = $urandom_range(8, 1);

      // pattern bytes: all ones, all zeros, fully random, or from a small alphabet
      r = $urandom_range(99);
      if (r < 8)       alphabet[0] = 8'hFF;
      else if (r < 14) alphabet[0] = 8'h00;
      foreach (cur_pat[i]) begin
        if (r < 14)                     cur_pat[i] = alphabet[0];
        else if (r < 24 || i >= len)    cur_pat[i] = byte_t'($urandom);
        else                            cur_pat[i] = alphabet[$urandom_range(ALPHA_N - 1)];
      end
      apply_pattern(len);
      if ($urandom_range(99) < 20) begin
        for (int k = FIRST_UNUSED_IDX; k < (1 << CFG_IDX_W); k++)
          write_reg(k[CFG_IDX_W-1:0], {$urandom, $urandom});
      end

      eff_len     = (len == 0) ? $urandom_range(4, 1) : ((len > PAT_BYTES) ? PAT_BYTES : len);
      chunk_len   = (phase == LONG_PHASE) ? 250 : $urandom_range(90, 30);
      begin_text  = ($urandom_range(99) < 70);
      phase_start = random_items;
      if (phase == HOLD_PHASE) rx_hold_req = 1'b1;

      while (random_items - phase_start < chunk_len) begin
        r = $urandom_range(99);
        if (r < 55) begin
          // whole pattern copy
          for (int i = 0; i < eff_len; i++) emit(cur_pat[i]);
        end else if (r < 72 && eff_len > 1) begin
          // prefix broken by one differing byte
          run_len = $urandom_range(eff_len - 1, 1);
          for (int i = 0; i < run_len; i++) emit(cur_pat[i]);
          emit(cur_pat[run_len] ^ byte_t'($urandom_range(255, 1)));
        end else if (r < 75) begin
          // sender pauses until everything has come back
          drain_results();
        end else begin
          // noise, mostly from the alphabet
          run_len = $urandom_range(4, 1);
          for (int i = 0; i < run_len; i++)
            emit(($urandom_range(99) < 80) ? alphabet[$urandom_range(ALPHA_N - 1)]
                                           : byte_t'($urandom));
        end
      end
      phase++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_q.size()));

    $display("Run covered %0d text bytes (%0d random) in %0d texts with %0d counted matches,",
             bytes_sent, random_items, texts_begun, matches_seen);
    $display("%0d register writes over %0d pattern settings, %0d results checked, %0d failures",
             cfg_writes, settings_used, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
